// ===== rtl/core/smwd_pkg.sv =====
// Shared types and constants for the sensor motion wake detector.
// Used by every module in rtl/core; depends on nothing else.
package smwd_pkg;

    localparam int NUM_CHANNELS   = 9;
    localparam int SLOT_BITS      = 16;
    localparam int FIELD_BITS     = 48;
    localparam int TIME_BITS      = 32;
    localparam int REG_BITS       = 16;
    localparam int ALPHA_BITS     = 9;
    localparam int ALPHA_SHIFT    = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int STATUS_BITS    = 2;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASELINE_ALPHA  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_READ_TIMEOUT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_GRACE      = 3'd4;

    // Configuration reset values.
    localparam logic [REG_BITS-1:0]   RST_SAMPLE_INTERVAL = 16'd100;
    localparam logic [REG_BITS-1:0]   RST_WAKE_THRESHOLD  = 16'd64;
    localparam logic [ALPHA_BITS-1:0] RST_BASELINE_ALPHA  = 9'd16;
    localparam logic [REG_BITS-1:0]   RST_READ_TIMEOUT    = 16'd1000;
    localparam logic [REG_BITS-1:0]   RST_WAKE_GRACE      = 16'd500;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_WAITING = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_WAKE    = 2'd2;

    typedef struct packed {
        logic [REG_BITS-1:0]   sample_interval;
        logic [REG_BITS-1:0]   wake_threshold;
        logic [ALPHA_BITS-1:0] alpha;
        logic [REG_BITS-1:0]   read_timeout;
        logic [REG_BITS-1:0]   wake_grace;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic update;
    } lane_cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   sample_taken;
        logic                   grace_active;
    } result_t;

endpackage

// ===== rtl/core/smwd_regs.sv =====
// Configuration register file of the motion wake detector.
// Depends on smwd_pkg for the register indexes, reset values and cfg_t.
module smwd_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [smwd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [smwd_pkg::REG_BITS-1:0]         cfg_data,
    output smwd_pkg::cfg_t                        cfg
);

    logic [smwd_pkg::REG_BITS-1:0]   interval_reg;
    logic [smwd_pkg::REG_BITS-1:0]   threshold_reg;
    logic [smwd_pkg::ALPHA_BITS-1:0] alpha_reg;
    logic [smwd_pkg::REG_BITS-1:0]   timeout_reg;
    logic [smwd_pkg::REG_BITS-1:0]   grace_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= smwd_pkg::RST_SAMPLE_INTERVAL;
            threshold_reg <= smwd_pkg::RST_WAKE_THRESHOLD;
            alpha_reg     <= smwd_pkg::RST_BASELINE_ALPHA;
            timeout_reg   <= smwd_pkg::RST_READ_TIMEOUT;
            grace_reg     <= smwd_pkg::RST_WAKE_GRACE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                smwd_pkg::REG_SAMPLE_INTERVAL: interval_reg  <= cfg_data;
                smwd_pkg::REG_WAKE_THRESHOLD:  threshold_reg <= cfg_data;
                smwd_pkg::REG_BASELINE_ALPHA:
                    alpha_reg <= cfg_data[smwd_pkg::ALPHA_BITS-1:0];
                smwd_pkg::REG_READ_TIMEOUT:    timeout_reg   <= cfg_data;
                smwd_pkg::REG_WAKE_GRACE:      grace_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficients above one are treated as one.
    always_comb
    begin
        cfg.sample_interval = interval_reg;
        cfg.wake_threshold  = threshold_reg;
        cfg.alpha           = (alpha_reg > smwd_pkg::ALPHA_ONE) ? smwd_pkg::ALPHA_ONE
                                                                : alpha_reg;
        cfg.read_timeout    = timeout_reg;
        cfg.wake_grace      = grace_reg;
    end

endmodule

// ===== rtl/core/smwd_lane.sv =====
// One channel of the detector: holds the fixed-point baseline, checks the
// sample against it and tracks it. Depends on smwd_pkg for lane_cmd_t.
module smwd_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                clk,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [smwd_pkg::REG_BITS-1:0]       wake_threshold,
    input  logic [smwd_pkg::ALPHA_BITS-1:0]     alpha,
    input  smwd_pkg::lane_cmd_t                 cmd,
    output logic                                motion
);

    localparam int W     = SAMPLE_BITS + FRAC_BITS;
    localparam int THR_W = smwd_pkg::REG_BITS + FRAC_BITS;
    localparam int CMP_W = (W + 1 > THR_W) ? W + 1 : THR_W;
    localparam int PW    = W + 1 + smwd_pkg::ALPHA_BITS + 1;

    logic signed [W-1:0]                    base_reg;
    logic signed [W-1:0]                    base_next;
    logic signed [W-1:0]                    scaled;
    logic signed [W:0]                      diff;
    logic [W:0]                             mag;
    logic [THR_W-1:0]                       thr;
    logic signed [smwd_pkg::ALPHA_BITS:0]   alpha_s;
    logic signed [PW-1:0]                   prod;
    logic signed [PW-1:0]                   step;

    assign scaled  = W'(sample) <<< FRAC_BITS;
    assign diff    = (W+1)'(scaled) - (W+1)'(base_reg);
    assign mag     = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
    assign thr     = THR_W'(wake_threshold) << FRAC_BITS;
    assign motion  = CMP_W'(mag) >= CMP_W'(thr);

    // The arithmetic shift rounds the tracking step toward minus infinity.
    assign alpha_s   = $signed({1'b0, alpha});
    assign prod      = PW'(diff) * PW'(alpha_s);
    assign step      = prod >>> smwd_pkg::ALPHA_SHIFT;
    assign base_next = base_reg + $signed(step[W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= scaled;
        end
        else if (cmd.update)
        begin
            base_reg <= base_next;
        end
    end

endmodule

// ===== rtl/core/smwd_ctrl.sv =====
// Session, read timing, timeout and wake decisions of the detector.
// Depends on smwd_pkg for cfg_t, lane_cmd_t, result_t and the status codes.
module smwd_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [smwd_pkg::TIME_BITS-1:0]    now_ms,
    input  logic                              host_activity,
    input  logic                              sleep_active,
    input  logic                              sensor_ok,
    input  logic                              motion_any,
    input  smwd_pkg::cfg_t                    cfg,
    output smwd_pkg::lane_cmd_t               cmd,
    output smwd_pkg::result_t                 result
);

    localparam int TW = smwd_pkg::TIME_BITS;

    logic          session_open_reg;
    logic          session_open_next;
    logic          baseline_valid_reg;
    logic          baseline_valid_next;
    logic [TW-1:0] last_good_read_reg;
    logic [TW-1:0] last_good_read_next;
    logic [TW-1:0] last_wake_reg;
    logic [TW-1:0] last_wake_next;

    logic          eff_valid;
    logic [TW-1:0] eff_good_read;
    logic [TW-1:0] read_age;
    logic [TW-1:0] gap;
    logic [TW-1:0] wake_age;
    logic          take;
    logic          check;
    logic          moved;
    logic          timed_out;

    always_comb
    begin
        // A poll with no open session starts one from this moment.
        eff_valid     = session_open_reg & baseline_valid_reg;
        eff_good_read = session_open_reg ? last_good_read_reg : now_ms;
        read_age      = now_ms - eff_good_read;
        take          = (sleep_active || read_age >= TW'(cfg.sample_interval)) && sensor_ok;
        check         = take && eff_valid;
        moved         = check && motion_any;

        last_good_read_next = take ? now_ms : eff_good_read;
        gap                 = now_ms - last_good_read_next;
        timed_out           = gap > TW'(cfg.read_timeout);

        last_wake_next      = last_wake_reg;
        session_open_next   = 1'b1;
        baseline_valid_next = eff_valid | take;
        result.status       = smwd_pkg::STATUS_WAITING;
        if (timed_out)
        begin
            session_open_next   = 1'b0;
            baseline_valid_next = 1'b0;
            result.status       = smwd_pkg::STATUS_TIMEOUT;
        end
        else if (moved || host_activity)
        begin
            last_wake_next      = now_ms;
            session_open_next   = 1'b0;
            baseline_valid_next = 1'b0;
            result.status       = smwd_pkg::STATUS_WAKE;
        end

        wake_age            = now_ms - last_wake_next;
        result.sample_taken = take;
        result.grace_active = wake_age <= TW'(cfg.wake_grace);

        cmd.load   = step && take && !eff_valid;
        cmd.update = step && check && !motion_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_open_reg   <= 1'b0;
            baseline_valid_reg <= 1'b0;
            last_good_read_reg <= '0;
            last_wake_reg      <= '0;
        end
        else if (step)
        begin
            session_open_reg   <= session_open_next;
            baseline_valid_reg <= baseline_valid_next;
            last_good_read_reg <= last_good_read_next;
            last_wake_reg      <= last_wake_next;
        end
    end

endmodule

// ===== rtl/core/sensor_motion_wake_detector.sv =====
// Top level of the sensor motion wake detector: input register, nine
// channel lanes, control and result register. Depends on smwd_pkg,
// smwd_regs, smwd_lane and smwd_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll per request: time
//   stamp, host and sleep flags, sensor_ok and nine packed samples.
//   Output channel (out_valid / out_stall) returns one result per poll:
//   status, sample_taken and grace_active, in poll order.
//   Configuration channel (cfg_valid / cfg_ready) writes one register per
//   request; cfg_ready is always high. Write only while the block is idle.
//   A poll accepted into the input register is evaluated against the stored
//   state, and its result is loaded into the result register, which drives
//   out_valid, once the output is not stalled. One poll is accepted every
//   cycle while the output does not stall; all nine lanes run in parallel.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall then rises until the output moves again.
//   Reset clears the session, the time stamps and the configuration to its
//   defaults; the channel baselines are written by the first good read.
module sensor_motion_wake_detector #(
    parameter int SAMPLE_BITS        = 16,
    parameter int BASELINE_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [smwd_pkg::TIME_BITS-1:0]        now_ms,
    input  logic                                  host_activity,
    input  logic                                  sleep_active,
    input  logic                                  sensor_ok,
    input  logic [smwd_pkg::FIELD_BITS-1:0]       sensor_a_xyz,
    input  logic [smwd_pkg::FIELD_BITS-1:0]       sensor_b_xyz,
    input  logic [smwd_pkg::FIELD_BITS-1:0]       sensor_c_xyz,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [smwd_pkg::STATUS_BITS-1:0]      status,
    output logic                                  sample_taken,
    output logic                                  grace_active,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [smwd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [smwd_pkg::REG_BITS-1:0]         cfg_data
);

    localparam int NCH = smwd_pkg::NUM_CHANNELS;
    localparam int SW  = NCH * smwd_pkg::SLOT_BITS;

    smwd_pkg::cfg_t       cfg;
    smwd_pkg::lane_cmd_t  cmd;
    smwd_pkg::result_t    result;

    logic                               in_valid_reg;
    logic [smwd_pkg::TIME_BITS-1:0]     now_reg;
    logic                               host_reg;
    logic                               sleep_reg;
    logic                               ok_reg;
    logic [SW-1:0]                      samples_reg;

    logic                               out_valid_reg;
    smwd_pkg::result_t                  result_reg;

    logic                               out_ready;
    logic                               step;
    logic                               in_take;
    logic [NCH-1:0]                     motion_vec;

    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    smwd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg     <= now_ms;
            host_reg    <= host_activity;
            sleep_reg   <= sleep_active;
            ok_reg      <= sensor_ok;
            samples_reg <= {sensor_c_xyz, sensor_b_xyz, sensor_a_xyz};
        end
    end

    // Channel k sits in the 16-bit slot k of the three concatenated fields.
    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_lane
        smwd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (BASELINE_FRAC_BITS)
        ) u_lane (
            .clk            (clk),
            .sample         ($signed(samples_reg[ch*smwd_pkg::SLOT_BITS +: SAMPLE_BITS])),
            .wake_threshold (cfg.wake_threshold),
            .alpha          (cfg.alpha),
            .cmd            (cmd),
            .motion         (motion_vec[ch])
        );
    end

    smwd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .now_ms        (now_reg),
        .host_activity (host_reg),
        .sleep_active  (sleep_reg),
        .sensor_ok     (ok_reg),
        .motion_any    (|motion_vec),
        .cfg           (cfg),
        .cmd           (cmd),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign sample_taken = result_reg.sample_taken;
    assign grace_active = result_reg.grace_active;

endmodule

// ===== rtl/core/smwd_checker.sv =====
// Port-level checks for the sensor motion wake detector, bound to the top.
// Depends on smwd_pkg for the status codes.
module smwd_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [smwd_pkg::STATUS_BITS-1:0]      status,
    input  logic                                  sample_taken,
    input  logic                                  grace_active
);

    // The input side only backs up when a result is waiting on the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // A wake stamps the wake time, so the grace window is open.
    a_wake_grace: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == smwd_pkg::STATUS_WAKE |-> grace_active)
        else $error("wake result without grace");

    // A good read resets the read age, so it can never time out.
    a_timeout_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == smwd_pkg::STATUS_TIMEOUT |-> !sample_taken)
        else $error("timeout reported on a poll that took a sample");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(sample_taken) && $stable(grace_active))
        else $error("stalled result changed");

endmodule

bind sensor_motion_wake_detector smwd_checker u_smwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .sample_taken (sample_taken),
    .grace_active (grace_active)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for sensor_motion_wake_detector: directed polls, then random
// polls under changing register settings, checked against a cycle-free predictor or
// typed-in results. Depends on smwd_pkg and the RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smwd_pkg::*;

    localparam int SAMPLE_W    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LATENCY_PAD = 4;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 170;

    // Index outside the register map; a write to it must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam logic [FIELD_BITS-1:0] ALL_MAX   = {3{16'h7FFF}};
    localparam logic [FIELD_BITS-1:0] ALL_MIN   = {3{16'h8000}};
    localparam logic [FIELD_BITS-1:0] MIXED     = {16'h0000, 16'hFFFF, 16'h0001};
    localparam logic [FIELD_BITS-1:0] CH_HI_64  = {16'd64, 32'd0};
    localparam logic [FIELD_BITS-1:0] CH_LO_M63 = {32'd0, 16'hFFC1};

    typedef struct packed {
        logic [TIME_BITS-1:0]  now;
        logic                  host;
        logic                  sleep;
        logic                  ok;
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] c;
    } poll_t;

    typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        poll_t                     poll;
        logic                      typed;
        result_t                   res;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [REG_BITS-1:0]       data;
    } row_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [TIME_BITS-1:0]      now_ms        = '0;
    logic                      host_activity = 1'b0;
    logic                      sleep_active  = 1'b0;
    logic                      sensor_ok     = 1'b0;
    logic [FIELD_BITS-1:0]     sensor_a_xyz  = '0;
    logic [FIELD_BITS-1:0]     sensor_b_xyz  = '0;
    logic [FIELD_BITS-1:0]     sensor_c_xyz  = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic [STATUS_BITS-1:0]    status;
    logic                      sample_taken;
    logic                      grace_active;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [REG_BITS-1:0]       cfg_data      = '0;

    // Predictor state and its copy of the registers.
    cfg_t                 model_cfg;
    bit                   sess_open    = 1'b0;
    bit                   base_valid   = 1'b0;
    logic [TIME_BITS-1:0] good_read_ms = '0;
    logic [TIME_BITS-1:0] wake_ms      = '0;
    longint               lane_base [NUM_CHANNELS];

    result_t expected_results [$];
    row_t    directed_plan [$];

    // Typed-in expectation that travels with the request on the input port.
    logic    drv_typed  = 1'b0;
    result_t drv_result = '0;

    bit                   quiet_mode = 1'b0;
    logic [TIME_BITS-1:0] clock_ms   = '0;
    int                   scene [NUM_CHANNELS];

    int cycles_run      = 0;
    int fail_count      = 0;
    int results_checked = 0;
    int wakes_seen      = 0;
    int timeouts_seen   = 0;
    int samples_seen    = 0;
    int reg_writes      = 0;

    sensor_motion_wake_detector #(
        .SAMPLE_BITS       (SAMPLE_W),
        .BASELINE_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .host_activity(host_activity),
        .sleep_active (sleep_active),
        .sensor_ok    (sensor_ok),
        .sensor_a_xyz (sensor_a_xyz),
        .sensor_b_xyz (sensor_b_xyz),
        .sensor_c_xyz (sensor_c_xyz),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sample_taken (sample_taken),
        .grace_active (grace_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advances the session and baseline state by one poll and returns its result.
    function automatic result_t predict_poll(input poll_t p);
        result_t               r;
        logic [FIELD_BITS-1:0] fld;
        logic [TIME_BITS-1:0]  dt;
        longint                s [NUM_CHANNELS];
        longint                d;
        longint                thr;
        longint                alpha;
        bit                    motion;
        bit                    taken;
        int                    k;
        motion = 1'b0;
        taken  = 1'b0;
        if (!sess_open)
        begin
            sess_open    = 1'b1;
            base_valid   = 1'b0;
            good_read_ms = p.now;
        end
        dt = p.now - good_read_ms;
        if ((p.sleep || dt >= model_cfg.sample_interval) && p.ok)
        begin
            taken        = 1'b1;
            good_read_ms = p.now;
            for (k = 0; k < NUM_CHANNELS; k++)
            begin
                fld  = (k < 3) ? p.a : ((k < 6) ? p.b : p.c);
                s[k] = $signed(fld[SAMPLE_W * (k % 3) +: SAMPLE_W]);
                s[k] = s[k] <<< FRAC_BITS;
            end
            if (!base_valid)
            begin
                for (k = 0; k < NUM_CHANNELS; k++)
                    lane_base[k] = s[k];
                base_valid = 1'b1;
            end
            else
            begin
                thr   = model_cfg.wake_threshold;
                thr   = thr <<< FRAC_BITS;
                alpha = (model_cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : model_cfg.alpha;
                for (k = 0; k < NUM_CHANNELS; k++)
                begin
                    d = s[k] - lane_base[k];
                    if (d < 0)
                        d = -d;
                    if (d >= thr)
                        motion = 1'b1;
                end
                // The arithmetic shift is a floor division, negative steps included.
                if (!motion)
                    for (k = 0; k < NUM_CHANNELS; k++)
                        lane_base[k] = lane_base[k]
                                     + ((alpha * (s[k] - lane_base[k])) >>> ALPHA_SHIFT);
            end
        end
        dt = p.now - good_read_ms;
        if (dt > model_cfg.read_timeout)
        begin
            sess_open  = 1'b0;
            base_valid = 1'b0;
            r.status   = STATUS_TIMEOUT;
        end
        else if (motion || p.host)
        begin
            wake_ms    = p.now;
            sess_open  = 1'b0;
            base_valid = 1'b0;
            r.status   = STATUS_WAKE;
        end
        else
        begin
            r.status = STATUS_WAITING;
        end
        r.sample_taken = taken;
        dt             = p.now - wake_ms;
        r.grace_active = (dt <= model_cfg.wake_grace);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        poll_t   seen;
        result_t want;
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("sensor_motion_wake_detector: mismatch");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    REG_SAMPLE_INTERVAL: model_cfg.sample_interval = cfg_data;
                    REG_WAKE_THRESHOLD:  model_cfg.wake_threshold  = cfg_data;
                    REG_BASELINE_ALPHA:  model_cfg.alpha           = cfg_data[ALPHA_BITS-1:0];
                    REG_READ_TIMEOUT:    model_cfg.read_timeout    = cfg_data;
                    REG_WAKE_GRACE:      model_cfg.wake_grace      = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                seen.now   = now_ms;
                seen.host  = host_activity;
                seen.sleep = sleep_active;
                seen.ok    = sensor_ok;
                seen.a     = sensor_a_xyz;
                seen.b     = sensor_b_xyz;
                seen.c     = sensor_c_xyz;
                want       = predict_poll(seen);
                if (drv_typed)
                    want = drv_result;
                expected_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no poll pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.status == STATUS_WAKE)
                        wakes_seen++;
                    if (want.status == STATUS_TIMEOUT)
                        timeouts_seen++;
                    if (want.sample_taken)
                        samples_seen++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (sample_taken !== want.sample_taken)
                    begin
                        $error("sample_taken: expected %0d, got %0d",
                               want.sample_taken, sample_taken);
                        fail_count++;
                    end
                    if (grace_active !== want.grace_active)
                    begin
                        $error("grace_active: expected %0d, got %0d",
                               want.grace_active, grace_active);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Idle length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        int hold;
        bit stalling;
        hold     = 0;
        stalling = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (quiet_mode)
                stalling = 1'b0;
            else
            begin
                stalling = !stalling;
                if (stalling)
                    hold = pick_gap();
                else
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                       : $urandom_range(0, 8);
            end
            out_stall <= stalling && !quiet_mode;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_poll(input poll_t p, input logic typed, input result_t res);
        int gap;
        in_valid      <= 1'b1;
        now_ms        <= p.now;
        host_activity <= p.host;
        sleep_active  <= p.sleep;
        sensor_ok     <= p.ok;
        sensor_a_xyz  <= p.a;
        sensor_b_xyz  <= p.b;
        sensor_c_xyz  <= p.c;
        drv_typed     <= typed;
        drv_result    <= res;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Holds off new requests until every pending result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic row_t poll_row(input logic [TIME_BITS-1:0] now, input logic host,
                                      input logic sleep, input logic ok,
                                      input logic [FIELD_BITS-1:0] a,
                                      input logic [FIELD_BITS-1:0] b,
                                      input logic [FIELD_BITS-1:0] c);
        row_t r;
        r         = '0;
        r.kind    = ROW_POLL;
        r.poll.now   = now;
        r.poll.host  = host;
        r.poll.sleep = sleep;
        r.poll.ok    = ok;
        r.poll.a     = a;
        r.poll.b     = b;
        r.poll.c     = c;
        return r;
    endfunction

    function automatic row_t with_result(input row_t r, input logic [STATUS_BITS-1:0] st,
                                         input logic taken, input logic grace);
        row_t t;
        t                  = r;
        t.typed            = 1'b1;
        t.res.status       = st;
        t.res.sample_taken = taken;
        t.res.grace_active = grace;
        return t;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                     input logic [REG_BITS-1:0] data);
        row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [REG_BITS-1:0] choose(input bit extreme,
                                                   input logic [REG_BITS-1:0] lo,
                                                   input logic [REG_BITS-1:0] hi,
                                                   input logic [REG_BITS-1:0] usual);
        if (!extreme)
            return usual;
        case ($urandom_range(0, 2))
            0:       return lo;
            1:       return hi;
            default: return usual;
        endcase
    endfunction

    // Polls around a steady scene: mostly small noise, sometimes one channel
    // jumping past the threshold, sometimes arbitrary bits.
    function automatic poll_t random_poll();
        poll_t                 p;
        logic [FIELD_BITS-1:0] f [3];
        int                    r;
        int                    v;
        int                    k;
        int                    amp;
        int                    hot;
        int                    thr;
        thr = model_cfg.wake_threshold;
        r   = $urandom_range(0, 99);
        if (r < 70)
            clock_ms += $urandom_range(0, 2 * model_cfg.sample_interval + 2);
        else if (r < 85)
            clock_ms += $urandom_range(0, 3);
        else if (r < 95)
            clock_ms += model_cfg.read_timeout + $urandom_range(1, 20);
        else
            clock_ms = $urandom;
        p.now   = clock_ms;
        p.host  = ($urandom_range(0, 19) == 0);
        p.sleep = ($urandom_range(0, 2) == 0);
        p.ok    = ($urandom_range(0, 6) != 0);
        amp     = (thr > 16000) ? 8000 : thr / 2;
        hot     = ($urandom_range(0, 6) == 0) ? $urandom_range(0, NUM_CHANNELS - 1) : -1;
        for (k = 0; k < NUM_CHANNELS; k++)
        begin
            v = scene[k] + int'($urandom_range(0, 2 * amp)) - amp;
            if (k == hot)
            begin
                v = scene[k] + thr + int'($urandom_range(0, 32));
                if ($urandom_range(0, 1) == 1)
                    v = 2 * scene[k] - v;
            end
            f[k / 3][SAMPLE_W * (k % 3) +: SAMPLE_W] = v[SAMPLE_W-1:0];
        end
        if ($urandom_range(0, 9) == 0)
            for (k = 0; k < 3; k++)
                f[k] = FIELD_BITS'({$urandom, $urandom});
        p.a = f[0];
        p.b = f[1];
        p.c = f[2];
        return p;
    endfunction

    initial
    begin : stimulus
        row_t row;
        bit   extreme;
        int   phase;
        int   n;
        int   k;
        model_cfg.sample_interval = RST_SAMPLE_INTERVAL;
        model_cfg.wake_threshold  = RST_WAKE_THRESHOLD;
        model_cfg.alpha           = RST_BASELINE_ALPHA;
        model_cfg.read_timeout    = RST_READ_TIMEOUT;
        model_cfg.wake_grace      = RST_WAKE_GRACE;
        for (k = 0; k < NUM_CHANNELS; k++)
            lane_base[k] = 0;

        // Reset defaults: session open, first copy, failed reads, timeout, wake paths.
        directed_plan.push_back(with_result(poll_row(32'd0, 1'b0, 1'b0, 1'b1, '0, '0, '0),
                                            STATUS_WAITING, 1'b0, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd100, 1'b0, 1'b0, 1'b1,
                                                     ALL_MAX, ALL_MIN, MIXED),
                                            STATUS_WAITING, 1'b1, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd200, 1'b0, 1'b0, 1'b1,
                                                     ALL_MAX, ALL_MIN, MIXED),
                                            STATUS_WAITING, 1'b1, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd300, 1'b0, 1'b1, 1'b0, '1, '1, '1),
                                            STATUS_WAITING, 1'b0, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd1201, 1'b0, 1'b0, 1'b0, '0, '1, '0),
                                            STATUS_TIMEOUT, 1'b0, 1'b0));
        directed_plan.push_back(with_result(poll_row(32'd1300, 1'b1, 1'b0, 1'b1, '1, '0, '1),
                                            STATUS_WAKE, 1'b0, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd1301, 1'b0, 1'b1, 1'b1, '0, '0, '0),
                                            STATUS_WAITING, 1'b1, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd1302, 1'b0, 1'b1, 1'b1,
                                                     '0, '0, CH_HI_64),
                                            STATUS_WAKE, 1'b1, 1'b1));
        directed_plan.push_back(with_result(poll_row(32'd1303, 1'b0, 1'b1, 1'b1, '0, '0, '0),
                                            STATUS_WAITING, 1'b1, 1'b1));
        directed_plan.push_back(poll_row(32'd1304, 1'b0, 1'b1, 1'b1, CH_LO_M63, '0, '0));
        directed_plan.push_back(poll_row(32'd1305, 1'b0, 1'b1, 1'b1, CH_LO_M63, '0, '0));
        // Time wrap around 2^32.
        directed_plan.push_back(poll_row(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1, '0, '0, '0));
        directed_plan.push_back(poll_row(32'h0000_0020, 1'b0, 1'b0, 1'b1, '0, '0, '0));
        directed_plan.push_back(poll_row(32'h0000_0060, 1'b0, 1'b0, 1'b1, '0, '0, '0));
        // Alpha above one is clamped, and the widest swing still reaches the top threshold.
        directed_plan.push_back(cfg_row(REG_BASELINE_ALPHA, 16'hFFFF));
        directed_plan.push_back(cfg_row(REG_WAKE_THRESHOLD, 16'hFFFF));
        directed_plan.push_back(poll_row(32'h61, 1'b0, 1'b1, 1'b1, {3{16'h1234}},
                                         {3{16'h1234}}, {3{16'h1234}}));
        directed_plan.push_back(poll_row(32'h62, 1'b0, 1'b1, 1'b1, {3{16'h1235}},
                                         {3{16'hEDCB}}, {3{16'h0100}}));
        directed_plan.push_back(poll_row(32'h63, 1'b0, 1'b1, 1'b1, ALL_MAX, ALL_MAX, ALL_MAX));
        directed_plan.push_back(with_result(poll_row(32'h64, 1'b0, 1'b1, 1'b1,
                                                     ALL_MIN, ALL_MIN, ALL_MIN),
                                            STATUS_WAKE, 1'b1, 1'b1));
        // Zero threshold: any read after the first copy is motion.
        directed_plan.push_back(cfg_row(REG_BASELINE_ALPHA, 16'd0));
        directed_plan.push_back(cfg_row(REG_WAKE_THRESHOLD, 16'd0));
        directed_plan.push_back(poll_row(32'h70, 1'b0, 1'b1, 1'b1, MIXED, ALL_MAX, ALL_MIN));
        directed_plan.push_back(with_result(poll_row(32'h71, 1'b0, 1'b1, 1'b1,
                                                     MIXED, ALL_MAX, ALL_MIN),
                                            STATUS_WAKE, 1'b1, 1'b1));
        // Zero interval, timeout and grace.
        directed_plan.push_back(cfg_row(REG_SAMPLE_INTERVAL, 16'd0));
        directed_plan.push_back(cfg_row(REG_READ_TIMEOUT, 16'd0));
        directed_plan.push_back(cfg_row(REG_WAKE_GRACE, 16'd0));
        directed_plan.push_back(cfg_row(REG_WAKE_THRESHOLD, 16'hFFFF));
        directed_plan.push_back(cfg_row(REG_BASELINE_ALPHA, 16'd300));
        directed_plan.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
        directed_plan.push_back(with_result(poll_row(32'h80, 1'b0, 1'b0, 1'b1, '0, '0, '0),
                                            STATUS_WAITING, 1'b1, 1'b0));
        directed_plan.push_back(with_result(poll_row(32'h81, 1'b0, 1'b0, 1'b0, '0, '0, '0),
                                            STATUS_TIMEOUT, 1'b0, 1'b0));
        directed_plan.push_back(with_result(poll_row(32'h82, 1'b1, 1'b0, 1'b0, '0, '0, '0),
                                            STATUS_WAKE, 1'b0, 1'b1));
        directed_plan.push_back(poll_row(32'h83, 1'b0, 1'b0, 1'b1, 48'h5A5A_A5A5_0F0F,
                                         48'hF0F0_3C3C_C3C3, 48'h0123_4567_89AB));
        directed_plan.push_back(cfg_row(REG_SAMPLE_INTERVAL, 16'hFFFF));
        directed_plan.push_back(cfg_row(REG_READ_TIMEOUT, 16'hFFFF));
        directed_plan.push_back(cfg_row(REG_WAKE_GRACE, 16'hFFFF));
        directed_plan.push_back(poll_row(32'h90, 1'b0, 1'b0, 1'b1, ALL_MIN, MIXED, ALL_MAX));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.idx, row.data);
            end
            else
                send_poll(row.poll, row.typed, row.res);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            extreme = (phase % 3 == 2);
            write_reg(REG_SAMPLE_INTERVAL,
                      choose(extreme, 16'd0, 16'hFFFF, REG_BITS'($urandom_range(1, 40))));
            write_reg(REG_WAKE_THRESHOLD,
                      choose(extreme, 16'd0, 16'hFFFF, REG_BITS'($urandom_range(8, 2000))));
            write_reg(REG_BASELINE_ALPHA,
                      choose(extreme, 16'd0, REG_BITS'($urandom_range(256, 65535)),
                             REG_BITS'($urandom_range(0, 300))));
            write_reg(REG_READ_TIMEOUT,
                      choose(extreme, 16'd0, 16'hFFFF, REG_BITS'($urandom_range(60, 600))));
            write_reg(REG_WAKE_GRACE,
                      choose(extreme, 16'd0, 16'hFFFF, REG_BITS'($urandom_range(0, 200))));
            quiet_mode = (phase == 4);
            clock_ms   = $urandom;
            for (k = 0; k < NUM_CHANNELS; k++)
                scene[k] = int'($urandom_range(0, 65535)) - 32768;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_poll(random_poll(), 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    settle();
            end
        end

        settle();
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Checked %0d results: %0d sampled, %0d wake, %0d timeout.",
                 results_checked, samples_seen, wakes_seen, timeouts_seen);
        $display("%0d register writes across %0d random settings, range extremes included.",
                 reg_writes, NUM_PHASES);
        if (fail_count == 0)
            $display("sensor_motion_wake_detector: match");
        else
            $display("sensor_motion_wake_detector: mismatch");
        $finish;
    end

endmodule
